@@ hdl/cul_pkg.sv @@
// ----------------------------------------------------------------------------
// cul_pkg: shared definitions for the compacting unique handle list
// Sizes, operation and status codes, and the control word that the top
// level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
`default_nettype none

package cul_pkg;

   // List sizing
   localparam int CAPACITY    = 16;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   // Width used to compare an 8-bit position against the entry count
   localparam int CMP_BITS    = (CNT_BITS > 8) ? CNT_BITS : 8;

   // Port field widths
   localparam int OP_W     = 3;
   localparam int HANDLE_W = 16;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 3'd0,
      OP_REMOVE_IDX = 3'd1,
      OP_REMOVE_HDL = 3'd2,
      OP_READ       = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_MISS  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   // Control word broadcast to all cells
   typedef struct packed {
      logic       do_write;   // write handle into the cell at idx
      logic       do_shift;   // cells at and above the drop point take neighbor
      logic       by_handle;  // drop point is first match, not idx
      idx_type    idx;        // write, drop or read index
      handle_type handle;     // handle to compare or write
      cnt_type    occ;        // current entry count
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hdl/cul_cell.sv @@
// ----------------------------------------------------------------------------
// cul_cell: one entry of the compacting handle list
// Holds one handle, compares it against the broadcast handle, passes
// match, drop and read chains to the next cell, and shifts in its upper
// neighbor's handle when it or an entry below it is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module cul_cell (
   input  wire                   clock,
   input  cul_pkg::idx_type      cell_index,
   input  cul_pkg::cell_ctl_type ctl,
   input  cul_pkg::handle_type   upper_entry,
   input  wire                   hit_prev,
   input  wire                   drop_prev,
   input  cul_pkg::handle_type   rd_prev,
   output cul_pkg::handle_type   entry,
   output logic                  hit_next,
   output logic                  drop_next,
   output cul_pkg::handle_type   rd_next
);
   import cul_pkg::*;

   handle_type entry_ff;
   handle_type entry_in;
   logic       occupied_here;
   logic       match;
   logic       idx_here;
   logic       drop_here;

   // Compare against the broadcast handle, only inside the occupied range
   always_comb begin
      occupied_here = CNT_BITS'(cell_index) < ctl.occ;
      match         = occupied_here && (entry_ff == ctl.handle);
      idx_here      = (cell_index == ctl.idx);
      drop_here     = ctl.by_handle ? (match && !hit_prev) : idx_here;
   end

   // Pass chains on to the next cell
   assign hit_next  = hit_prev | match;
   assign drop_next = drop_prev | drop_here;
   assign rd_next   = rd_prev | (idx_here ? entry_ff : '0);
   assign entry     = entry_ff;

   // Write, shift down or hold
   always_comb begin
      priority if (ctl.do_write && idx_here) begin
         entry_in = ctl.handle;
      end else if (ctl.do_shift && drop_next) begin
         entry_in = upper_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ hdl/compacting_unique_handle_list_core.sv @@
// ----------------------------------------------------------------------------
// compacting_unique_handle_list_core: bounded unique handle list
// A row of cells keeps handles, zero included, packed at the front. Supports
// insert, remove at index, remove by handle, clamped read and clear.
//
//   channel | ports                                  | direction
//   req     | valid, stall, operation, handle, pos.  | in
//   rsp     | valid, stall, status, read_handle, cnt | out
//
// One item is taken per cycle unless the response side stalls; its result
// appears in the output register on the next cycle. All cells compare, shift
// and read together over ripple chains; the count register closes the loop.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result holds the output register and stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_unique_handle_list_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [cul_pkg::OP_W-1:0]     req_operation,
   input  wire  [cul_pkg::HANDLE_W-1:0] req_handle,
   input  wire  signed [cul_pkg::POS_W-1:0] req_position,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [cul_pkg::STATUS_W-1:0] rsp_status,
   output logic [cul_pkg::HANDLE_W-1:0] rsp_read_handle,
   output logic [cul_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import cul_pkg::*;

   // Control and count state
   cnt_type                occ_ff, occ_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [HANDLE_W-1:0]    rd_ff, rd_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic                   accept;
   cell_ctl_type           ctl;
   handle_type             handle_w;
   logic                   pos_neg;
   logic [CMP_BITS-1:0]    pos_u;
   logic                   pos_in_range;
   idx_type                read_idx;
   logic                   full;
   logic                   dup;
   status_type             status;
   logic                   do_write;
   logic                   do_shift;

   // Chains along the row
   handle_type             ent_chain [0:CAPACITY];
   logic                   hit_chain [0:CAPACITY];
   logic                   drop_chain [0:CAPACITY];
   handle_type             rd_chain  [0:CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Decode position and count
   always_comb begin
      handle_w     = handle_type'(req_handle);
      pos_neg      = req_position[POS_W-1];
      pos_u        = CMP_BITS'(req_position[POS_W-2:0]);
      pos_in_range = !pos_neg && (pos_u < CMP_BITS'(occ_ff));
      full         = (occ_ff >= CNT_BITS'(CAPACITY));
      priority if (pos_neg) begin
         read_idx = '0;
      end else if (pos_in_range) begin
         read_idx = IDX_BITS'(pos_u);
      end else begin
         read_idx = IDX_BITS'(occ_ff - CNT_BITS'(1));
      end
   end

   // Drive the chain ends
   assign hit_chain[0]         = 1'b0;
   assign drop_chain[0]        = 1'b0;
   assign rd_chain[0]          = '0;
   assign ent_chain[CAPACITY]  = ent_chain[CAPACITY-1];
   assign dup                  = hit_chain[CAPACITY];

   // Operation decode: status, writes, shifts and next count
   always_comb begin
      status   = ST_DONE;
      do_write = 1'b0;
      do_shift = 1'b0;
      occ_in   = occ_ff;
      rd_in    = '0;
      ctl.by_handle = 1'b0;
      ctl.idx       = read_idx;
      unique case (op_type'(req_operation))
         OP_INSERT: begin
            ctl.idx = IDX_BITS'(occ_ff);
            priority if (full) begin
               status = ST_FULL;
            end else if (dup) begin
               status = ST_DUP;
            end else begin
               do_write = 1'b1;
               occ_in   = occ_ff + CNT_BITS'(1);
            end
         end
         OP_REMOVE_IDX: begin
            ctl.idx = IDX_BITS'(pos_u);
            if (pos_in_range) begin
               do_shift = 1'b1;
               occ_in   = occ_ff - CNT_BITS'(1);
            end else begin
               status = ST_MISS;
            end
         end
         OP_REMOVE_HDL: begin
            ctl.by_handle = 1'b1;
            if (dup) begin
               do_shift = 1'b1;
               occ_in   = occ_ff - CNT_BITS'(1);
            end else begin
               status = ST_MISS;
            end
         end
         OP_READ: begin
            if (occ_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_in = HANDLE_W'(rd_chain[CAPACITY]);
            end
         end
         OP_CLEAR: begin
            occ_in = '0;
         end
         default: begin
            status = ST_MISS;
         end
      endcase
      ctl.do_write = accept & do_write;
      ctl.do_shift = accept & do_shift;
      ctl.handle   = handle_w;
      ctl.occ      = occ_ff;
   end

   // Row of cells
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      cul_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_BITS'(k)),
         .ctl         (ctl),
         .upper_entry (ent_chain[k+1]),
         .hit_prev    (hit_chain[k]),
         .drop_prev   (drop_chain[k]),
         .rd_prev     (rd_chain[k]),
         .entry       (ent_chain[k]),
         .hit_next    (hit_chain[k+1]),
         .drop_next   (drop_chain[k+1]),
         .rd_next     (rd_chain[k+1])
      );
   end

   // Result register: load on accept, drop once taken
   always_comb begin
      status_in = status;
      count_in  = COUNT_W'(occ_in);
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rd_ff     <= rd_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_handle = rd_ff;
   assign rsp_entry_count = count_ff;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_entry_count == COUNT_W'(CAPACITY))
      else $error("full status with list not full");

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY)
         |-> (rsp_entry_count == '0 && rsp_read_handle == '0))
      else $error("empty status with entries present");

endmodule

`default_nettype wire
